// ===== sv/lrc_pf_pkg.sv =====
`default_nettype none

package lrc_pf_pkg;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ERR = 8'h00;

    localparam int MAX_BEATS = 8;
    localparam int IDX_W     = $clog2(MAX_BEATS);

    localparam logic [IDX_W-1:0] LAST_ERR    = IDX_W'(0);
    localparam logic [IDX_W-1:0] LAST_EMPTY  = IDX_W'(6);
    localparam logic [IDX_W-1:0] LAST_SINGLE = IDX_W'(7);
    localparam logic [IDX_W-1:0] LAST_OPEN   = IDX_W'(4);
    localparam logic [IDX_W-1:0] LAST_CONT   = IDX_W'(0);
    localparam logic [IDX_W-1:0] LAST_CLOSE  = IDX_W'(3);

    typedef logic [7:0] byte_t;

    // All output beats caused by one input item.
    typedef struct packed {
        byte_t [MAX_BEATS-1:0] beats;
        logic  [IDX_W-1:0]     last_idx;
        logic                  close;
        logic                  err;
    } desc_t;

endpackage

`default_nettype wire

// ===== sv/lrc_packet_framer_unit.sv =====
// The first beat of an item's results is offered in the cycle after the item is accepted.
// An item causing n result beats (n from 1 to 8) holds the output until its last beat is taken.
// Non-final continuation items give one beat each: one item per cycle unless m_tready is low.
// The output beat register is the only buffer; a new item is taken as the last beat leaves.
// Reset is asynchronous and active low; it closes any open frame and empties the output.
`default_nettype none

module lrc_packet_framer_unit
    import lrc_pf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // payload_length[15:0], data_byte[23:16]
    input  wire logic        s_tuser,   // start_req
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte[7:0]
    output logic             m_tlast,
    output logic [1:0]       m_tuser    // run_last[0], seq_error[1]
);

    desc_t desc;
    logic  accept;

    assign accept = s_tvalid && s_tready;

    lrc_pf_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .start_req      (s_tuser),
        .payload_length (s_tdata[15:0]),
        .data_byte      (s_tdata[23:16]),
        .desc           (desc)
    );

    lrc_pf_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .desc_in   (desc),
        .can_load  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_byte  (m_tdata),
        .frame_end (m_tlast),
        .run_last  (m_tuser[0]),
        .seq_error (m_tuser[1])
    );

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0] && !m_tlast)
        else $error("Error beat is not a single closing beat.");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0] && m_tdata == CH_EOT)
        else $error("Frame end is not the final EOT beat.");

    a_accept_shows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("Accepted beat produced no output.");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("Input stalled while output is empty.");

endmodule

`default_nettype wire

// ===== sv/lrc_pf_ctrl.sv =====
`default_nettype none

module lrc_pf_ctrl
    import lrc_pf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        start_req,
    input  wire logic [15:0] payload_length,
    input  wire logic [7:0]  data_byte,
    output desc_t            desc
);

    logic        in_frame_reg;
    logic        in_frame_next;
    logic [15:0] bytes_left_reg;
    logic [15:0] bytes_left_next;
    logic [7:0]  byte_sum_reg;
    logic [7:0]  byte_sum_next;

    logic        err;
    logic        last_byte;
    logic [7:0]  sum_new;
    logic [7:0]  lrc;

    assign err       = (start_req == in_frame_reg);
    assign sum_new   = (start_req ? 8'h00 : byte_sum_reg) + data_byte;
    assign lrc       = 8'h00 - sum_new;
    assign last_byte = start_req ? (payload_length == 16'd1) : (bytes_left_reg <= 16'd1);

    always_comb
    begin
        desc            = '0;
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        byte_sum_next   = byte_sum_reg;
        if (err)
        begin
            desc.err      = 1'b1;
            desc.beats[0] = CH_ERR;
            desc.last_idx = LAST_ERR;
        end
        else if (start_req)
        begin
            desc.beats[0] = CH_SOH;
            desc.beats[1] = payload_length[7:0];
            desc.beats[2] = payload_length[15:8];
            desc.beats[3] = CH_STX;
            if (payload_length == 16'd0)
            begin
                desc.beats[4] = CH_ETX;
                desc.beats[5] = 8'h00;
                desc.beats[6] = CH_EOT;
                desc.last_idx = LAST_EMPTY;
                desc.close    = 1'b1;
            end
            else if (last_byte)
            begin
                desc.beats[4] = data_byte;
                desc.beats[5] = CH_ETX;
                desc.beats[6] = lrc;
                desc.beats[7] = CH_EOT;
                desc.last_idx = LAST_SINGLE;
                desc.close    = 1'b1;
            end
            else
            begin
                desc.beats[4]   = data_byte;
                desc.last_idx   = LAST_OPEN;
                in_frame_next   = 1'b1;
                bytes_left_next = payload_length - 16'd1;
                byte_sum_next   = sum_new;
            end
        end
        else
        begin
            desc.beats[0] = data_byte;
            if (last_byte)
            begin
                desc.beats[1]   = CH_ETX;
                desc.beats[2]   = lrc;
                desc.beats[3]   = CH_EOT;
                desc.last_idx   = LAST_CLOSE;
                desc.close      = 1'b1;
                in_frame_next   = 1'b0;
                bytes_left_next = 16'd0;
                byte_sum_next   = 8'h00;
            end
            else
            begin
                desc.last_idx   = LAST_CONT;
                bytes_left_next = bytes_left_reg - 16'd1;
                byte_sum_next   = sum_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 16'd0;
            byte_sum_reg   <= 8'h00;
        end
        else if (accept)
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            byte_sum_reg   <= byte_sum_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lrc_pf_ser.sv =====
`default_nettype none

module lrc_pf_ser
    import lrc_pf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire desc_t      desc_in,
    output logic            can_load,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      out_byte,
    output logic            frame_end,
    output logic            run_last,
    output logic            seq_error
);

    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    desc_t            desc_reg;
    logic             at_last;

    assign at_last   = (idx_reg == desc_reg.last_idx);
    assign can_load  = !busy_reg || (m_tready && at_last);
    assign m_tvalid  = busy_reg;
    assign out_byte  = desc_reg.beats[idx_reg];
    assign frame_end = desc_reg.close && at_last;
    assign run_last  = at_last;
    assign seq_error = desc_reg.err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (busy_reg && m_tready)
        begin
            if (at_last)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= desc_in;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/lrc_framer_checker.sv =====
`timescale 1ns / 1ps

module lrc_framer_checker
    import lrc_pf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // payload_length[15:0], data_byte[23:16]
    input  wire logic        s_tuser,   // start_req
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,   // out_byte[7:0]
    input  wire logic        m_tlast,
    input  wire logic [1:0]  m_tuser,   // run_last[0], seq_error[1]
    output int               fail_count,
    output int               pending,
    output int               beats_checked
);

    typedef struct packed {
        logic [7:0] value;
        logic       frame_end;
        logic       run_last;
        logic       seq_error;
    } tx_byte_t;

    tx_byte_t   frame_bytes_due[$];
    tx_byte_t   item_bytes [0:MAX_BEATS-1];
    int         item_len = 0;
    logic       frame_open = 1'b0;
    logic [15:0] bytes_left = 16'd0;
    logic [7:0]  byte_sum = 8'd0;
    int         fails = 0;
    int         checked = 0;

    task add_byte(input logic [7:0] value, input logic frame_end, input logic seq_error);
        item_bytes[item_len].value = value;
        item_bytes[item_len].frame_end = frame_end;
        item_bytes[item_len].run_last = 1'b0;
        item_bytes[item_len].seq_error = seq_error;
        item_len++;
    endtask

    task add_trailer();
        logic [7:0] lrc;
        lrc = 8'h00 - byte_sum;
        add_byte(CH_ETX, 1'b0, 1'b0);
        add_byte(lrc, 1'b0, 1'b0);
        add_byte(CH_EOT, 1'b1, 1'b0);
        frame_open = 1'b0;
        bytes_left = 16'd0;
        byte_sum = 8'd0;
    endtask

    task add_payload(input logic [7:0] value);
        add_byte(value, 1'b0, 1'b0);
        byte_sum = byte_sum + value;
        if (bytes_left <= 16'd1)
            add_trailer();
        else
            bytes_left = bytes_left - 16'd1;
    endtask

    task predict_frame_bytes(input logic start, input logic [15:0] len,
                             input logic [7:0] data);
        item_len = 0;
        if (start == frame_open)
        begin
            add_byte(CH_ERR, 1'b0, 1'b1);
        end
        else if (start)
        begin
            add_byte(CH_SOH, 1'b0, 1'b0);
            add_byte(len[7:0], 1'b0, 1'b0);
            add_byte(len[15:8], 1'b0, 1'b0);
            add_byte(CH_STX, 1'b0, 1'b0);
            byte_sum = 8'd0;
            if (len == 16'd0)
            begin
                add_trailer();
            end
            else
            begin
                frame_open = 1'b1;
                bytes_left = len;
                add_payload(data);
            end
        end
        else
        begin
            add_payload(data);
        end
        item_bytes[item_len-1].run_last = 1'b1;
        for (int i = 0; i < item_len; i++)
            frame_bytes_due.push_back(item_bytes[i]);
    endtask

    task compare_tx_byte(input logic [7:0] value, input logic frame_end,
                         input logic [1:0] flags);
        tx_byte_t want;
        if (frame_bytes_due.size() == 0)
        begin
            $error("unexpected beat: out_byte %h", value);
            fails++;
        end
        else
        begin
            want = frame_bytes_due.pop_front();
            checked++;
            if (value !== want.value)
            begin
                $error("out_byte mismatch: expected %h, actual %h", want.value, value);
                fails++;
            end
            if (frame_end !== want.frame_end)
            begin
                $error("frame_end mismatch: expected %b, actual %b", want.frame_end, frame_end);
                fails++;
            end
            if (flags[0] !== want.run_last)
            begin
                $error("run_last mismatch: expected %b, actual %b", want.run_last, flags[0]);
                fails++;
            end
            if (flags[1] !== want.seq_error)
            begin
                $error("seq_error mismatch: expected %b, actual %b", want.seq_error, flags[1]);
                fails++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            frame_bytes_due.delete();
            frame_open = 1'b0;
            bytes_left = 16'd0;
            byte_sum = 8'd0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                compare_tx_byte(m_tdata, m_tlast, m_tuser);
            if (s_tvalid && s_tready)
                predict_frame_bytes(s_tuser, s_tdata[15:0], s_tdata[23:16]);
        end
        fail_count <= fails;
        pending <= frame_bytes_due.size();
        beats_checked <= checked;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 2000;
    localparam int TARGET_BEATS = 450;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = 24'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    int fail_count;
    int pending;
    int beats_checked;

    int burst_left = 0;
    int payload_beats = 0;
    int frames_sent = 0;
    int empty_frames = 0;
    int bad_beats = 0;
    int longest_frame = 0;
    int stuck_cycles = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_tick = 0;

    lrc_packet_framer_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    lrc_framer_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(32, 200);
        end
        else
        begin
            rx_mode_left--;
        end
        rx_tick++;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= (rx_tick % 3 == 0);
            default: m_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= STALL_LIMIT)
            begin
                $display("lrc_packet_framer_unit verification failed");
                $finish;
            end
        end
    end

    task send_beat(input logic start, input logic [15:0] len, input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 10);
            repeat (gap)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser <= start;
        s_tdata <= {data, len};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
    endtask

    task send_bad_beat(input logic start);
        send_beat(start, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        bad_beats++;
    endtask

    task send_frame(input int len, input int bad_pct);
        send_beat(1'b1, 16'(len), 8'($urandom_range(0, 255)));
        payload_beats++;
        frames_sent++;
        if (len == 0)
            empty_frames++;
        if (len > longest_frame)
            longest_frame = len;
        for (int i = 1; i < len; i++)
        begin
            if ($urandom_range(0, 99) < bad_pct)
                send_bad_beat(1'b1);
            send_beat(1'b0, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            payload_beats++;
        end
    endtask

    task drain_output();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int pick;
        int len;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: idle continuations, empty and one-byte frames, starts inside a frame.
        send_beat(1'b0, 16'hffff, 8'hff);
        send_beat(1'b0, 16'h0000, 8'h00);
        bad_beats += 2;
        send_beat(1'b1, 16'h0000, 8'h5a);
        send_beat(1'b1, 16'h0001, 8'h00);
        send_beat(1'b1, 16'h0001, 8'hff);
        send_beat(1'b1, 16'h0003, 8'hff);
        send_beat(1'b1, 16'hffff, 8'h11);
        send_beat(1'b0, 16'hffff, 8'hff);
        send_beat(1'b1, 16'h0000, 8'h00);
        send_beat(1'b0, 16'h0000, 8'hff);
        bad_beats += 2;
        send_beat(1'b1, 16'h0002, 8'h80);
        send_beat(1'b0, 16'h0000, 8'h80);
        send_beat(1'b1, 16'h0002, 8'h01);
        send_beat(1'b0, 16'h5555, 8'hff);
        send_beat(1'b1, 16'h0002, 8'haa);
        send_beat(1'b0, 16'haaaa, 8'h55);
        frames_sent += 7;
        empty_frames += 1;
        drain_output();

        send_frame(257, 0);
        drain_output();

        while (payload_beats + bad_beats < TARGET_BEATS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                send_bad_beat(1'b0);
            end
            else if (pick < 10)
            begin
                drain_output();
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    len = 0;
                else if (pick < 25)
                    len = 1;
                else if (pick < 75)
                    len = $urandom_range(2, 8);
                else if (pick < 97)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(41, 64);
                send_frame(len, 4);
            end
        end

        drain_output();
        repeat (16) @(posedge clk);

        $display("Sent %0d frames (%0d empty, longest %0d bytes) and %0d out-of-sequence beats.",
                 frames_sent, empty_frames, longest_frame, bad_beats);
        $display("Checked %0d output beats against the predicted frame bytes.", beats_checked);
        if (fail_count == 0 && pending == 0)
            $display("lrc_packet_framer_unit verification clean");
        else
            $display("lrc_packet_framer_unit verification failed");
        $finish;
    end

endmodule

// ===== lrc_packet_framer_unit.f =====
sv/lrc_pf_pkg.sv
sv/lrc_pf_ctrl.sv
sv/lrc_pf_ser.sv
sv/lrc_packet_framer_unit.sv
tb/sv/lrc_framer_checker.sv
tb/sv/tb_top.sv
